>>> rtl/srt_pkg.sv
// Shared types, constants and helper functions for the script run tokenizer.
// Used by srt_word_buf and script_run_tokenizer; depends on nothing else.
package srt_pkg;

    localparam int MAX_WORD = 32;
    localparam int CP_W     = 21;
    localparam int LEN_W    = $clog2(MAX_WORD + 1);
    localparam int IDX_W    = $clog2(MAX_WORD);

    typedef logic [CP_W-1:0]  cp_t;
    typedef logic [LEN_W-1:0] len_t;
    typedef logic [IDX_W-1:0] idx_t;

    localparam cp_t HIRA_LO     = 21'h03040;
    localparam cp_t HIRA_HI     = 21'h0309F;
    localparam cp_t KATA_LO     = 21'h030A0;
    localparam cp_t KATA_HI     = 21'h030FF;
    localparam cp_t KANJI_LO    = 21'h04E00;
    localparam cp_t KANJI_HI    = 21'h09FAF;
    localparam cp_t ASCII_END   = 21'h00080;
    localparam cp_t CJK_PUNC_LO = 21'h03000;
    localparam cp_t CJK_PUNC_HI = 21'h0303F;
    localparam cp_t KANA_SHIFT  = 21'h00060;
    localparam len_t PARTICLE_MAX_LEN = len_t'(2);

    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_HIRA  = 2'd1,
        CLS_KATA  = 2'd2,
        CLS_KANJI = 2'd3
    } cls_t;

    typedef enum logic [2:0] {
        CAT_PARTICLE = 3'd0,
        CAT_VERB     = 3'd1,
        CAT_NOUN     = 3'd2,
        CAT_SYMBOL   = 3'd3,
        CAT_UNKNOWN  = 3'd4
    } cat_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic        text_end;
    } char_t;

    typedef struct packed {
        logic [20:0] surface_char;
        logic [20:0] reading_char;
        logic [2:0]  category;
        logic        token_end;
        logic        batch_end;
        logic        final_result;
    } token_t;

    // Word buffer access for one cycle.
    typedef struct packed {
        logic wr_en;
        idx_t wr_addr;
        cp_t  wr_data;
        logic rd_en;
        idx_t rd_addr;
    } buf_req_t;

    function automatic cls_t char_class(input cp_t c);
        cls_t cls;
        cls = CLS_NONE;
        if (c >= HIRA_LO && c <= HIRA_HI) cls = CLS_HIRA;
        else if (c >= KATA_LO && c <= KATA_HI) cls = CLS_KATA;
        else if (c >= KANJI_LO && c <= KANJI_HI) cls = CLS_KANJI;
        return cls;
    endfunction

    function automatic logic is_punct(input cp_t c);
        return (c < ASCII_END) || (c >= CJK_PUNC_LO && c <= CJK_PUNC_HI);
    endfunction

    function automatic cat_t word_category(input cls_t first_cls, input len_t len);
        cat_t cat;
        case (first_cls)
            CLS_HIRA:  cat = (len <= PARTICLE_MAX_LEN) ? CAT_PARTICLE : CAT_VERB;
            CLS_KATA:  cat = CAT_NOUN;
            CLS_KANJI: cat = CAT_NOUN;
            default:   cat = CAT_UNKNOWN;
        endcase
        return cat;
    endfunction

endpackage

>>> rtl/srt_word_buf.sv
// Word buffer: one write port and one read port with registered read data.
// Depends on srt_pkg for the depth, widths and the access request struct.
module srt_word_buf (
    input  logic             clk,
    input  srt_pkg::buf_req_t req,
    output srt_pkg::cp_t     rd_data
);

    srt_pkg::cp_t mem [srt_pkg::MAX_WORD];
    srt_pkg::cp_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/script_run_tokenizer.sv
// Script run tokenizer: splits a code point stream into word and symbol tokens.
// Each accepted item passes S_MID, which buffers a word character or presents a symbol token;
// a word is replayed through the buffer read port, each character via S_READ then S_EMIT.
// Items are taken only in S_IDLE, not while one is in work; output stalls can hold S_EMIT and S_MID.
// Reset is asynchronous and clears the sequencer and word state; buffer contents stay
// undefined, and no entry is read before it is written.
module script_run_tokenizer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            char_valid,
    output logic            char_ready,
    input  srt_pkg::char_t  char_data,
    output logic            token_valid,
    input  logic            token_ready,
    output srt_pkg::token_t token_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EMIT = 4'b0100,
        S_MID  = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    srt_pkg::len_t   len_reg, len_next;
    srt_pkg::idx_t   idx_reg, idx_next;
    srt_pkg::cls_t   prev_reg, prev_next;
    srt_pkg::cls_t   first_cls_reg, first_cls_next;
    logic            all_hira_reg, all_hira_next;
    logic            tail_reg, tail_next;
    logic            out_valid_reg, out_valid_next;
    srt_pkg::token_t out_reg, out_next;

    srt_pkg::cp_t    cp_reg, cp_next;
    logic            last_reg, last_next;
    logic            punct_reg, punct_next;
    srt_pkg::cls_t   cls_reg, cls_next;

    srt_pkg::buf_req_t req;
    srt_pkg::cp_t      rd_data;

    logic            out_free;
    logic            load;
    logic            word_last;
    logic            boundary;
    srt_pkg::cls_t   in_cls;
    logic            in_punct;

    srt_word_buf u_buf (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    assign char_ready  = (state_reg == S_IDLE);
    assign token_valid = out_valid_reg;
    assign token_data  = out_reg;
    assign out_free    = !out_valid_reg || token_ready;

    assign in_cls   = srt_pkg::char_class(char_data.code_point);
    assign in_punct = srt_pkg::is_punct(char_data.code_point);
    assign word_last = ((srt_pkg::len_t'(idx_reg) + srt_pkg::len_t'(1)) == len_reg);

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        prev_next      = prev_reg;
        first_cls_next = first_cls_reg;
        all_hira_next  = all_hira_reg;
        tail_next      = tail_reg;
        cp_next        = cp_reg;
        last_next      = last_reg;
        punct_next     = punct_reg;
        cls_next       = cls_reg;
        out_next       = out_reg;
        load           = 1'b0;
        req            = '0;
        boundary       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (char_valid)
                begin
                    cp_next    = char_data.code_point;
                    last_next  = char_data.text_end;
                    punct_next = in_punct;
                    cls_next   = in_cls;
                    // A full buffer also forces a flush before the new character goes in.
                    boundary = in_punct || (in_cls != srt_pkg::CLS_NONE && in_cls != prev_reg)
                               || (len_reg == srt_pkg::len_t'(srt_pkg::MAX_WORD));
                    if (len_reg != '0 && boundary)
                    begin
                        idx_next   = '0;
                        tail_next  = 1'b0;
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_MID;
                    end
                end
            end
            S_READ:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = idx_reg;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    out_next.surface_char = rd_data;
                    out_next.reading_char = all_hira_reg ? (rd_data + srt_pkg::KANA_SHIFT)
                                                         : rd_data;
                    out_next.category     = srt_pkg::word_category(first_cls_reg, len_reg);
                    out_next.token_end    = word_last;
                    // The leading flush is the last beat only when nothing follows it.
                    out_next.batch_end    = word_last &&
                                            (tail_reg || (!punct_reg && !last_reg));
                    out_next.final_result = word_last && tail_reg;
                    if (word_last)
                    begin
                        len_next      = '0;
                        all_hira_next = 1'b1;
                        state_next    = tail_reg ? S_IDLE : S_MID;
                    end
                    else
                    begin
                        idx_next   = idx_reg + srt_pkg::idx_t'(1);
                        state_next = S_READ;
                    end
                end
            end
            S_MID:
            begin
                if (punct_reg)
                begin
                    if (out_free)
                    begin
                        load = 1'b1;
                        out_next.surface_char = cp_reg;
                        out_next.reading_char = cp_reg;
                        out_next.category     = srt_pkg::CAT_SYMBOL;
                        out_next.token_end    = 1'b1;
                        out_next.batch_end    = 1'b1;
                        out_next.final_result = last_reg;
                        prev_next  = srt_pkg::CLS_NONE;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = len_reg[srt_pkg::IDX_W-1:0];
                    req.wr_data = cp_reg;
                    len_next    = len_reg + srt_pkg::len_t'(1);
                    if (len_reg == '0)
                    begin
                        first_cls_next = cls_reg;
                    end
                    if (cls_reg != srt_pkg::CLS_HIRA)
                    begin
                        all_hira_next = 1'b0;
                    end
                    prev_next = last_reg ? srt_pkg::CLS_NONE : cls_reg;
                    if (last_reg)
                    begin
                        idx_next   = '0;
                        tail_next  = 1'b1;
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (token_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            idx_reg       <= '0;
            prev_reg      <= srt_pkg::CLS_NONE;
            all_hira_reg  <= 1'b1;
            tail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            prev_reg      <= prev_next;
            all_hira_reg  <= all_hira_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_cls_reg <= first_cls_next;
        cp_reg        <= cp_next;
        last_reg      <= last_next;
        punct_reg     <= punct_next;
        cls_reg       <= cls_next;
        out_reg       <= out_next;
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= srt_pkg::len_t'(srt_pkg::MAX_WORD))
        else $error("word length exceeds buffer depth");

    a_empty_hira: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg == '0) |-> all_hira_reg)
        else $error("empty word buffer without hiragana flag set");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && char_ready) |=> (state_reg != S_IDLE))
        else $error("sequencer stayed idle after accepting a beat");

    a_final_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (token_valid && token_data.final_result) |->
            (token_data.batch_end && token_data.token_end))
        else $error("final result beat does not close its token and batch");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (len_reg != '0))
        else $error("buffer replay started on an empty word");

endmodule
